// ----- hw/rtl/tcs_pkg.sv -----
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared constants and types for the TSV column selector.
// ----------------------------------------------------------------------------
package tcs_pkg;

	localparam int MAX_COLS_DEF = 4;

	localparam int BYTE_W  = 8;
	localparam int CIU_W   = 3;
	localparam int LINE_W  = 32;
	localparam int CFG_W   = 8;
	localparam int IDX_W   = 3;

	localparam logic [BYTE_W-1:0] TAB_CHAR = 8'h09;
	localparam logic [BYTE_W-1:0] NL_CHAR  = 8'h0A;

	localparam logic [CIU_W-1:0]  COLS_IN_USE_RST   = 3'd4;
	localparam logic [BYTE_W-1:0] EXPECTED_TABS_RST = 8'd3;
	localparam logic [BYTE_W-1:0] TAB_MAX           = 8'hFF;
	localparam logic [LINE_W-1:0] LINE_MAX          = 32'hFFFF_FFFF;
	localparam logic [LINE_W-1:0] LINE_RST          = 32'd1;

	typedef enum logic [IDX_W-1:0] {
		REG_COLS_IN_USE   = 3'd0,
		REG_SELECT_COL_0  = 3'd1,
		REG_SELECT_COL_1  = 3'd2,
		REG_SELECT_COL_2  = 3'd3,
		REG_SELECT_COL_3  = 3'd4,
		REG_EXPECTED_TABS = 3'd5
	} cfg_idx_t;

	function automatic logic [LINE_W-1:0] sat_inc(input logic [LINE_W-1:0] v);
		return (v == LINE_MAX) ? v : v + LINE_W'(1);
	endfunction

endpackage

// ----- hw/rtl/tsv_column_selector.sv -----
// Each result passes through the input register and then the output register,
// from which it leaves when m_tready is high.
// Throughput: one byte per cycle; the input register advances whenever the
// output register is empty or being taken, so only a stalled output slows it.
// Bytes with no result (header, unselected cols) still use the input register.
// Reset (arst_n low) restores all configuration and line state at once.
// ----------------------------------------------------------------------------
// tsv_column_selector
// Drops the header line, passes selected columns of each TSV line and checks
// the tab count of every non-empty line; halts on the first bad line.
// ----------------------------------------------------------------------------
module tsv_column_selector #(
	parameter int MAX_COLS = tcs_pkg::MAX_COLS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,   // in_byte[7:0]
	input  logic                       s_tuser,   // end_of_input
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [39:0]                m_tdata,   // out_byte[7:0], bad_line[39:8]
	output logic                       m_tuser,   // malformed
	input  logic                       cfg_we,
	input  logic [tcs_pkg::IDX_W-1:0]  cfg_index,
	input  logic [tcs_pkg::CFG_W-1:0]  cfg_data
);
	import tcs_pkg::*;

	logic [CIU_W-1:0]  cols_in_use_q;
	logic [BYTE_W-1:0] select_col_q [MAX_COLS];
	logic [BYTE_W-1:0] expected_tabs_q;

	logic              header_done_q;
	logic [BYTE_W-1:0] tab_count_q;
	logic [LINE_W-1:0] line_counter_q;
	logic              line_nonempty_q;
	logic              halted_q;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              end_s1;

	logic              m_tvalid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              malformed_q;
	logic [LINE_W-1:0] bad_line_q;

	logic              adv;
	logic [CIU_W-1:0]  n_eff;
	logic              hit;
	logic              hit_last;
	logic              line_bad;

	logic              emit;
	logic              emit_bad;
	logic [BYTE_W-1:0] emit_byte;
	logic              header_done_d;
	logic [BYTE_W-1:0] tab_count_d;
	logic [LINE_W-1:0] line_counter_d;
	logic              line_nonempty_d;
	logic              halted_d;

	assign adv      = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_in_use_q   <= COLS_IN_USE_RST;
			expected_tabs_q <= EXPECTED_TABS_RST;
			for (int i = 0; i < MAX_COLS; i++) begin
				select_col_q[i] <= BYTE_W'(i);
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COLS_IN_USE:   cols_in_use_q   <= cfg_data[CIU_W-1:0];
				REG_EXPECTED_TABS: expected_tabs_q <= cfg_data;
				default: begin
					for (int i = 0; i < MAX_COLS; i++) begin
						if (cfg_index == IDX_W'(REG_SELECT_COL_0) + IDX_W'(i))
							select_col_q[i] <= cfg_data;
					end
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			end_s1  <= s_tuser;
		end
	end

	// slot match, first slot wins
	assign n_eff    = (cols_in_use_q > CIU_W'(MAX_COLS)) ? CIU_W'(MAX_COLS) : cols_in_use_q;
	assign line_bad = line_nonempty_q && (tab_count_q != expected_tabs_q);

	always_comb begin
		hit      = 1'b0;
		hit_last = 1'b0;
		for (int i = 0; i < MAX_COLS; i++) begin
			if (!hit && (CIU_W'(i) < n_eff) && (tab_count_q == select_col_q[i])) begin
				hit      = 1'b1;
				hit_last = !(CIU_W'(i + 1) < n_eff);
			end
		end
	end

	always_comb begin
		emit            = 1'b0;
		emit_bad        = 1'b0;
		emit_byte       = byte_s1;
		header_done_d   = header_done_q;
		tab_count_d     = tab_count_q;
		line_counter_d  = line_counter_q;
		line_nonempty_d = line_nonempty_q;
		halted_d        = halted_q;
		if (halted_q) begin
			emit = 1'b0;
		end else if (end_s1) begin
			if (header_done_q && line_bad) begin
				emit     = 1'b1;
				emit_bad = 1'b1;
				halted_d = 1'b1;
			end
		end else if (!header_done_q) begin
			if (byte_s1 == NL_CHAR)
				header_done_d = 1'b1;
		end else if (byte_s1 == NL_CHAR) begin
			emit = 1'b1;
			if (line_bad) begin
				emit_bad = 1'b1;
				halted_d = 1'b1;
			end else begin
				tab_count_d     = '0;
				line_nonempty_d = 1'b0;
				line_counter_d  = sat_inc(line_counter_q);
			end
		end else begin
			if (hit && ((byte_s1 != TAB_CHAR) || !hit_last))
				emit = 1'b1;
			if (byte_s1 == TAB_CHAR && tab_count_q != TAB_MAX)
				tab_count_d = tab_count_q + BYTE_W'(1);
			line_nonempty_d = 1'b1;
		end
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_done_q   <= 1'b0;
			tab_count_q     <= '0;
			line_counter_q  <= LINE_RST;
			line_nonempty_q <= 1'b0;
			halted_q        <= 1'b0;
		end else if (adv) begin
			header_done_q   <= header_done_d;
			tab_count_q     <= tab_count_d;
			line_counter_q  <= line_counter_d;
			line_nonempty_q <= line_nonempty_d;
			halted_q        <= halted_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= emit;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			out_byte_q  <= emit_bad ? '0 : emit_byte;
			malformed_q <= emit_bad;
			bad_line_q  <= emit_bad ? sat_inc(line_counter_q) : '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {bad_line_q, out_byte_q};
	assign m_tuser  = malformed_q;

	a_bad_sets_halt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> halted_q)
		else $error("malformed result without halt");

	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q && !m_tvalid |=> !m_tvalid)
		else $error("result produced while halted");

	a_good_no_line: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[39:8] == '0)
		else $error("normal result carries a line number");

	a_header_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!header_done_q |-> (line_counter_q == LINE_RST) && !line_nonempty_q &&
			(tab_count_q == '0))
		else $error("line state moved inside header");

	a_header_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!header_done_q && !m_tvalid |=> !m_tvalid)
		else $error("result produced before header end");

endmodule
